@@ design/ptw_pkg.sv @@
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared constants, types and the register map of the page table walker.
// ----------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

  // Table window size in 64-bit words (512 .. 65536).
  localparam int TABLE_WORDS = 4096;
  localparam int WORD_AW     = $clog2(TABLE_WORDS);

  // Largest byte offset of a 4 KiB table that still fits in the window.
  localparam logic [55:0] MAX_TABLE_OFF = 56'(TABLE_WORDS * 8 - 4096);

  // Command codes.
  localparam logic CMD_WRITE     = 1'b0;
  localparam logic CMD_TRANSLATE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ROOT_TABLE  = 2'd0;
  localparam logic [1:0] CFG_WINDOW_BASE = 2'd1;
  localparam logic [1:0] CFG_USER_LOW    = 2'd2;
  localparam logic [1:0] CFG_USER_HIGH   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LVL1,
    ST_LVL0,
    ST_LEAF
  } walk_state_e;

  typedef struct packed {
    logic [55:0] root_table_address;
    logic [55:0] window_base;
    logic [38:0] user_low_bound;
    logic [39:0] user_high_bound;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [WORD_AW-1:0] waddr;
    logic [63:0]        wdata;
    logic               re;
    logic [WORD_AW-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

@@ design/ptw_mem.sv @@
// ----------------------------------------------------------------------------
// ptw_mem
// Page table word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_mem (
  input  wire logic              clk_i,
  input  wire ptw_pkg::mem_req_t req_i,
  output logic [63:0]            rdata_o
);
  import ptw_pkg::*;

  logic [63:0] mem_q [TABLE_WORDS];
  logic [63:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/ptw_walker.sv @@
// ----------------------------------------------------------------------------
// ptw_walker
// Command sequencer: stores table words and walks the three table levels,
// one memory read per level, then checks the leaf and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_walker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ptw_pkg::cfg_t     cfg_i,
  input  wire logic              start_i,
  input  wire logic              command_i,
  input  wire logic [11:0]       word_index_i,
  input  wire logic [63:0]       word_data_i,
  input  wire logic [38:0]       virtual_address_i,
  input  wire logic [2:0]        required_rights_i,
  output ptw_pkg::mem_req_t      mem_req_o,
  input  wire logic [63:0]       mem_rdata_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic                   granted_o,
  output logic [55:0]            phys_addr_o
);
  import ptw_pkg::*;

  walk_state_e state_q, state_d;
  logic        fail_q, fail_d;
  logic [38:0] va_q, va_d;
  logic [2:0]  rights_q, rights_d;
  logic        done_q, done_d;
  logic        granted_q, granted_d;
  logic [55:0] pa_q, pa_d;

  logic               accept;
  logic               out_of_bounds;
  logic               index_in_range;
  logic               leaf_ok;
  logic [55:0]        tbl_addr;
  logic [8:0]         tbl_idx;
  logic [56:0]        tbl_diff;
  logic               win_ok;
  logic [WORD_AW-1:0] win_word;

  assign accept = start_i && (state_q == ST_IDLE);

  assign out_of_bounds = (virtual_address_i < cfg_i.user_low_bound) ||
                         ({1'b0, virtual_address_i} >= cfg_i.user_high_bound);
  assign index_in_range = (32'(word_index_i) < 32'(TABLE_WORDS));

  // The root comes from the register as written; lower levels take the
  // page-aligned address field of the entry just read.
  always_comb begin
    case (state_q)
      ST_LVL1: begin
        tbl_addr = {mem_rdata_i[55:12], 12'h000};
        tbl_idx  = va_q[29:21];
      end
      ST_LVL0: begin
        tbl_addr = {mem_rdata_i[55:12], 12'h000};
        tbl_idx  = va_q[20:12];
      end
      default: begin
        tbl_addr = cfg_i.root_table_address;
        tbl_idx  = virtual_address_i[38:30];
      end
    endcase
  end

  // The table must start at or above the window base and fit entirely in it;
  // then the word index cannot leave the memory.
  assign tbl_diff = {1'b0, tbl_addr} - {1'b0, cfg_i.window_base};
  assign win_ok   = !tbl_diff[56] && (tbl_diff[55:0] <= MAX_TABLE_OFF);
  assign win_word = WORD_AW'(tbl_diff[55:3]) + WORD_AW'(tbl_idx);

  assign leaf_ok = mem_rdata_i[0] && mem_rdata_i[4] &&
                   ((mem_rdata_i[3:1] & rights_q) == rights_q);

  always_comb begin
    state_d   = state_q;
    fail_d    = fail_q;
    va_d      = va_q;
    rights_d  = rights_q;
    done_d    = 1'b0;
    granted_d = 1'b0;
    pa_d      = '0;

    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = WORD_AW'(word_index_i);
    mem_req_o.wdata = word_data_i;
    mem_req_o.re    = 1'b0;
    mem_req_o.raddr = win_word;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (command_i == CMD_WRITE) begin
            mem_req_o.we = index_in_range;
            done_d       = 1'b1;
          end else begin
            mem_req_o.re = 1'b1;
            fail_d       = out_of_bounds || !win_ok;
            va_d         = virtual_address_i;
            rights_d     = required_rights_i;
            state_d      = ST_LVL1;
          end
        end
      end
      ST_LVL1: begin
        mem_req_o.re = 1'b1;
        fail_d       = fail_q || !mem_rdata_i[0] || !win_ok;
        state_d      = ST_LVL0;
      end
      ST_LVL0: begin
        mem_req_o.re = 1'b1;
        fail_d       = fail_q || !mem_rdata_i[0] || !win_ok;
        state_d      = ST_LEAF;
      end
      ST_LEAF: begin
        done_d    = 1'b1;
        granted_d = !fail_q && leaf_ok;
        if (granted_d) begin
          pa_d = {mem_rdata_i[55:12], va_q[11:0]};
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fail_q    <= 1'b0;
      done_q    <= 1'b0;
      granted_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fail_q    <= fail_d;
      done_q    <= done_d;
      granted_q <= granted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    va_q     <= va_d;
    rights_q <= rights_d;
    pa_q     <= pa_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign granted_o   = granted_q;
  assign phys_addr_o = pa_q;

  a_done_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("result strobe while a walk is in progress");

  a_grant_with_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    granted_q |-> done_q)
    else $error("grant without result strobe");

  a_refused_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !granted_q) |-> (pa_q == '0))
    else $error("refused result carries a nonzero address");

  a_leaf_answers : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LEAF) |=> done_q)
    else $error("leaf check gave no result");

  a_walk_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i == CMD_TRANSLATE) |=> (state_q == ST_LVL1))
    else $error("translation accepted but walk did not start");

endmodule

`default_nettype wire

@@ design/three_level_page_table_walk_top.sv @@
// ----------------------------------------------------------------------------
// three_level_page_table_walk_top
// Three-level page table walker over a window of page table memory.
// ----------------------------------------------------------------------------
//  Channel   Handshake                 Payload
//  command   start_i & !busy_o         command_i, word_index_i, word_data_i,
//                                      virtual_address_i, required_rights_i
//  result    done_o (one cycle)        granted_o, phys_addr_o
//  config    cfg_we_i                  cfg_index_i, cfg_wdata_i
//
//  A table word write answers in the cycle after it is accepted; busy_o stays
//  low, so commands may follow back to back.
//  A translation answers once the three dependent reads of the table memory,
//  each with registered read data, and the leaf check are done; busy_o is
//  high while the walk is in progress.
//  The result word is shown for one cycle only; the receiver cannot stall.
//  Reset is asynchronous and active low; the table memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module three_level_page_table_walk_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [55:0] cfg_wdata_i,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        command_i,
  input  wire logic [11:0] word_index_i,
  input  wire logic [63:0] word_data_i,
  input  wire logic [38:0] virtual_address_i,
  input  wire logic [2:0]  required_rights_i,
  output logic             done_o,
  output logic             granted_o,
  output logic [55:0]      phys_addr_o
);
  import ptw_pkg::*;

  cfg_t        cfg_q;
  mem_req_t    mem_req;
  logic [63:0] mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.root_table_address <= '0;
      cfg_q.window_base        <= '0;
      cfg_q.user_low_bound     <= 39'd4096;
      cfg_q.user_high_bound    <= 40'h80_0000_0000;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ROOT_TABLE:  cfg_q.root_table_address <= cfg_wdata_i;
        CFG_WINDOW_BASE: cfg_q.window_base        <= cfg_wdata_i;
        CFG_USER_LOW:    cfg_q.user_low_bound     <= cfg_wdata_i[38:0];
        CFG_USER_HIGH:   cfg_q.user_high_bound    <= cfg_wdata_i[39:0];
        default: begin
        end
      endcase
    end
  end

  ptw_walker u_walker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .start_i            (start_i),
    .command_i          (command_i),
    .word_index_i       (word_index_i),
    .word_data_i        (word_data_i),
    .virtual_address_i  (virtual_address_i),
    .required_rights_i  (required_rights_i),
    .mem_req_o          (mem_req),
    .mem_rdata_i        (mem_rdata),
    .busy_o             (busy_o),
    .done_o             (done_o),
    .granted_o          (granted_o),
    .phys_addr_o        (phys_addr_o)
  );

  ptw_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire
